@@ sv/rbfc_pkg.sv @@
// shared types, constants and tables of the filter calibration sequencer
`timescale 1ns / 1ps

package rbfc_pkg;

	localparam int NUM_BANDS  = 6;
	localparam int BIAS_STEPS = 32;

	localparam int LEVEL_W    = 16;
	localparam int VALUE_W    = 11;
	localparam int KIND_W     = 3;
	localparam int BAND_W     = 3;
	localparam int GAIN_W     = 6;
	localparam int BIAS_W     = 5;
	localparam int RES_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NRES_W     = 2;
	localparam int NRES_MAX   = 3;

	// input opcodes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] K_BIAS   = 3'd0;
	localparam logic [KIND_W-1:0] K_RES    = 3'd1;
	localparam logic [KIND_W-1:0] K_GAIN   = 3'd2;
	localparam logic [KIND_W-1:0] K_CAP    = 3'd3;
	localparam logic [KIND_W-1:0] K_REPORT = 3'd4;
	localparam logic [KIND_W-1:0] K_DONE   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_START     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP_START      = 2'd2;

	localparam logic [LEVEL_W-1:0] GAIN_THRESHOLD_RST = 16'd52428;
	localparam logic [GAIN_W-1:0]  GAIN_START_RST     = 6'd24;
	localparam logic [VALUE_W-1:0] CAP_START_RST      = 11'h0FF;

	localparam logic [GAIN_W-1:0]  GAIN_MAX     = 6'd63;
	localparam logic [BIAS_W-1:0]  BIAS_DEFAULT = 5'd16;
	localparam logic [BIAS_W-1:0]  BIAS_LAST    = BIAS_W'(BIAS_STEPS - 1);
	localparam logic [BAND_W-1:0]  BAND_END     = BAND_W'(NUM_BANDS);

	// floor(256 / code) saturated at 31; code zero gives 31
	localparam logic [RES_W-1:0] RES_LUT [32] = '{
		5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
		5'd31, 5'd28, 5'd25, 5'd23, 5'd21, 5'd19, 5'd18, 5'd17,
		5'd16, 5'd15, 5'd14, 5'd13, 5'd12, 5'd12, 5'd11, 5'd11,
		5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd8,  5'd8
	};

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [BAND_W-1:0]  band;
		logic               ok;
		logic               last;
	} res_t;

	typedef struct packed {
		logic              load;
		logic              eval;
		logic [NRES_W-1:0] idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [NRES_W-1:0] n_res;
	} dp_stat_t;

endpackage

@@ sv/rbfc_if.sv @@
// valid/ready channel interfaces for commands, measurements and results
`timescale 1ns / 1ps

interface rbfc_in_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [rbfc_pkg::LEVEL_W-1:0] level;

	modport source (output valid, output op, output level, input ready);
	modport sink (input valid, input op, input level, output ready);
endinterface

interface rbfc_out_if;
	logic                         valid;
	logic                         ready;
	logic [rbfc_pkg::KIND_W-1:0]  kind;
	logic [rbfc_pkg::VALUE_W-1:0] value;
	logic [rbfc_pkg::BAND_W-1:0]  band;
	logic                         ok;
	logic                         last;

	modport source (output valid, output kind, output value, output band, output ok,
		output last, input ready);
	modport sink (input valid, input kind, input value, input band, input ok,
		input last, output ready);
endinterface

@@ sv/rbfc_ctrl.sv @@
// controller: sequences accept, evaluate and result transfer for one item at a time
`timescale 1ns / 1ps

module rbfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  rbfc_pkg::dp_stat_t  stat,
	output rbfc_pkg::ctrl_cmd_t cmd
);
	import rbfc_pkg::*;

	localparam logic [1:0] S_IN   = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [NRES_W-1:0] idx_q;

	always_comb begin
		in_ready  = (state_q == S_IN);
		out_valid = (state_q == S_OUT) && (stat.n_res != '0);
		cmd.load  = in_valid && in_ready;
		cmd.eval  = (state_q == S_EVAL);
		cmd.idx   = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IN;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IN: begin
					if (cmd.load) begin
						state_q <= S_EVAL;
						idx_q   <= '0;
					end
				end
				S_EVAL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// an ignored measurement leaves nothing to send
					if (stat.n_res == '0) begin
						state_q <= S_IN;
					end else if (out_ready) begin
						if (idx_q == stat.n_res - NRES_W'(1)) begin
							state_q <= S_IN;
						end else begin
							idx_q <= idx_q + NRES_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

	a_load_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.eval)
		else $error("evaluate did not follow accepted item");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < stat.n_res))
		else $error("result index beyond result count");

	a_sides_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

endmodule

@@ sv/rbfc_dp.sv @@
// datapath: calibration state, search decisions and result buffer
`timescale 1ns / 1ps

module rbfc_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rbfc_pkg::ctrl_cmd_t              cmd,
	output rbfc_pkg::dp_stat_t               stat,
	input  logic                             in_op,
	input  logic [rbfc_pkg::LEVEL_W-1:0]     in_level,
	input  logic                             cfg_we,
	input  logic [rbfc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [rbfc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output rbfc_pkg::res_t                   out_item
);
	import rbfc_pkg::*;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_A    = 3'd1;
	localparam logic [2:0] PH_B0   = 3'd2;
	localparam logic [2:0] PH_B1   = 3'd3;
	localparam logic [2:0] PH_F    = 3'd4;

	function automatic logic [GAIN_W-1:0] gain_step(input logic [GAIN_W-1:0] g,
		input logic rising);
		logic [GAIN_W-1:0] r;
		r = g;
		if (rising) begin
			if (g != GAIN_MAX) r = g + GAIN_W'(1);
		end else begin
			if (g != '0) r = g - GAIN_W'(1);
		end
		return r;
	endfunction

	function automatic res_t mk(input logic [KIND_W-1:0] kind,
		input logic [VALUE_W-1:0] value, input logic [BAND_W-1:0] band, input logic ok);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.band  = band;
		r.ok    = ok;
		r.last  = 1'b0;
		return r;
	endfunction

	// configuration registers
	logic [LEVEL_W-1:0] thr_q;
	logic [GAIN_W-1:0]  gain_start_q;
	logic [VALUE_W-1:0] cap_start_q;

	// latched input item
	logic               op_q;
	logic [LEVEL_W-1:0] level_q;

	// calibration state
	logic [2:0]         phase_q;
	logic [BIAS_W-1:0]  bias_q;
	logic [LEVEL_W-1:0] best_level_q;
	logic [BIAS_W-1:0]  best_bias_q;
	logic [GAIN_W-1:0]  gain_q;
	logic               rising_q;
	logic [LEVEL_W-1:0] target_q;
	logic [BAND_W-1:0]  band_q;
	logic [VALUE_W-1:0] cap_q;

	logic [2:0]         nx_phase;
	logic [BIAS_W-1:0]  nx_bias;
	logic [LEVEL_W-1:0] nx_best_level;
	logic [BIAS_W-1:0]  nx_best_bias;
	logic [GAIN_W-1:0]  nx_gain;
	logic               nx_rising;
	logic [LEVEL_W-1:0] nx_target;
	logic [BAND_W-1:0]  nx_band;
	logic [VALUE_W-1:0] nx_cap;

	res_t               it0, it1, it2;
	logic [NRES_W-1:0]  n_res;
	logic               done;
	logic               rise_new;
	logic [BAND_W-1:0]  band_inc;

	res_t               buf_q [NRES_MAX];
	logic [NRES_W-1:0]  n_res_q;

	always_comb begin
		nx_phase      = phase_q;
		nx_bias       = bias_q;
		nx_best_level = best_level_q;
		nx_best_bias  = best_bias_q;
		nx_gain       = gain_q;
		nx_rising     = rising_q;
		nx_target     = target_q;
		nx_band       = band_q;
		nx_cap        = cap_q;
		it0           = '0;
		it1           = '0;
		it2           = '0;
		n_res         = '0;
		rise_new      = (level_q < thr_q);
		band_inc      = band_q + BAND_W'(1);
		done          = rising_q ? (level_q >= thr_q) : (level_q <= thr_q);
		if ((gain_q == '0) || (gain_q == GAIN_MAX)) done = 1'b1;

		if (op_q == OP_START) begin
			// a start abandons whatever run is going on
			nx_phase      = PH_A;
			nx_bias       = '0;
			nx_best_level = '0;
			nx_best_bias  = BIAS_DEFAULT;
			it0           = mk(K_BIAS, '0, '0, 1'b0);
			n_res         = NRES_W'(1);
		end else begin
			case (phase_q)
				PH_A: begin
					if (bias_q == '0) begin
						nx_best_level = level_q;
					end else if (level_q < best_level_q) begin
						nx_best_level = level_q;
						nx_best_bias  = bias_q;
					end
					if (bias_q != BIAS_LAST) begin
						nx_bias = bias_q + BIAS_W'(1);
						it0     = mk(K_BIAS, VALUE_W'(nx_bias), '0, 1'b0);
						n_res   = NRES_W'(1);
					end else begin
						nx_gain  = gain_start_q;
						nx_phase = PH_B0;
						it0      = mk(K_BIAS, VALUE_W'(nx_best_bias), '0, 1'b0);
						it1      = mk(K_RES, VALUE_W'(RES_LUT[nx_best_bias]), '0, 1'b0);
						it2      = mk(K_GAIN, VALUE_W'(gain_start_q), '0, 1'b0);
						n_res    = NRES_W'(3);
					end
				end
				PH_B0: begin
					nx_rising = rise_new;
					nx_gain   = gain_step(gain_q, rise_new);
					nx_phase  = PH_B1;
					it0       = mk(K_GAIN, VALUE_W'(nx_gain), '0, 1'b0);
					n_res     = NRES_W'(1);
				end
				PH_B1: begin
					if (done) begin
						nx_target = level_q;
						nx_band   = '0;
						nx_phase  = PH_F;
						nx_cap    = cap_start_q;
						it0       = mk(K_CAP, cap_start_q, '0, 1'b0);
					end else begin
						nx_gain = gain_step(gain_q, rising_q);
						it0     = mk(K_GAIN, VALUE_W'(nx_gain), '0, 1'b0);
					end
					n_res = NRES_W'(1);
				end
				PH_F: begin
					if ((level_q >= target_q) || (cap_q == '0)) begin
						// band settles, or fails once the code has run down to zero
						if (level_q >= target_q) begin
							it0 = mk(K_REPORT, cap_q, band_q, 1'b1);
						end else begin
							it0 = mk(K_REPORT, '0, band_q, 1'b0);
						end
						nx_band = band_inc;
						if (band_inc < BAND_END) begin
							nx_cap = cap_start_q;
							it1    = mk(K_CAP, cap_start_q, band_inc, 1'b0);
						end else begin
							nx_phase = PH_IDLE;
							it1      = mk(K_DONE, '0, '0, 1'b1);
						end
						n_res = NRES_W'(2);
					end else begin
						nx_cap = cap_q - VALUE_W'(1);
						it0    = mk(K_CAP, nx_cap, band_q, 1'b0);
						n_res  = NRES_W'(1);
					end
				end
				default: begin
					// measurement while idle is dropped
				end
			endcase
		end
		it0.last = (n_res == NRES_W'(1));
		it1.last = (n_res == NRES_W'(2));
		it2.last = (n_res == NRES_W'(3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q        <= GAIN_THRESHOLD_RST;
			gain_start_q <= GAIN_START_RST;
			cap_start_q  <= CAP_START_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_GAIN_THRESHOLD: thr_q        <= cfg_data[LEVEL_W-1:0];
				CFG_GAIN_START:     gain_start_q <= cfg_data[GAIN_W-1:0];
				CFG_CAP_START:      cap_start_q  <= cfg_data[VALUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			level_q <= in_level;
		end
		if (cmd.eval) begin
			buf_q[0] <= it0;
			buf_q[1] <= it1;
			buf_q[2] <= it2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bias_q       <= '0;
			best_level_q <= '0;
			best_bias_q  <= BIAS_DEFAULT;
			gain_q       <= '0;
			rising_q     <= 1'b0;
			target_q     <= '0;
			band_q       <= '0;
			cap_q        <= '0;
			n_res_q      <= '0;
		end else if (cmd.eval) begin
			phase_q      <= nx_phase;
			bias_q       <= nx_bias;
			best_level_q <= nx_best_level;
			best_bias_q  <= nx_best_bias;
			gain_q       <= nx_gain;
			rising_q     <= nx_rising;
			target_q     <= nx_target;
			band_q       <= nx_band;
			cap_q        <= nx_cap;
			n_res_q      <= n_res;
		end
	end

	assign stat.n_res = n_res_q;
	assign out_item   = buf_q[cmd.idx];

	a_band_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_F) |-> (band_q < BAND_END))
		else $error("band search past last band");

	a_results_when_active: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && ((op_q == OP_START) || (phase_q != PH_IDLE))) |=> (n_res_q != '0))
		else $error("active item produced no result");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eval && (op_q == OP_MEASURE) && (phase_q == PH_F) && (nx_phase == PH_IDLE))
		|=> (n_res_q == NRES_W'(2)))
		else $error("run end without report and finish");

endmodule

@@ sv/rbfc_filter_calibration_top_placeholder.sv @@
// port-side protocol checker for the command and result channels
`timescale 1ns / 1ps

module rbfc_cfg_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            out_last
);
	// port-side checker of the two channels

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("input valid dropped before transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_last)))
		else $error("result changed before transfer");

	a_no_accept_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_last) |=> !in_ready)
		else $error("input taken before last result");

	a_ready_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("both sides open at once");

endmodule

@@ sv/rbb_filter_calibration_sequencer_top.sv @@
// top level of the receive filter calibration sequencer
`timescale 1ns / 1ps
//
// in_ch carries commands: op 0 starts a calibration run, op 1 delivers the level
// measured for the setting last issued. out_ch carries the settings to apply
// (bias, resistor, gain, capacitor), per-band reports and a finished marker;
// last marks the final result caused by one input transfer (up to three results).
// cfg_we/cfg_idx/cfg_data write gain_threshold (0), gain_start (1), cap_start (2);
// write only while no item is in flight.
// Timing: an input transfer is evaluated in the next cycle; its first result is
// valid from the cycle after that; results then move one per cycle while
// out_ch.ready is high. in_ch.ready returns the cycle after the last result
// transfer, as the controller sequences accept, evaluate and send per item.
// A stalled receiver holds the current result and keeps in_ch.ready low.
// Reset (arst_n low) puts the sequencer idle, loads the register defaults and
// drops any pending results; no clearing pass is needed.
//
module rbb_filter_calibration_sequencer_top (
	input  logic                                clk,
	input  logic                                arst_n,
	rbfc_in_if.sink                             in_ch,
	rbfc_out_if.source                          out_ch,
	input  logic                                cfg_we,
	input  logic [rbfc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [rbfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rbfc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	res_t      item;

	rbfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rbfc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_op    (in_ch.op),
		.in_level (in_ch.level),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.out_item (item)
	);

	rbfc_cfg_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_last  (out_ch.last)
	);

	assign out_ch.kind  = item.kind;
	assign out_ch.value = item.value;
	assign out_ch.band  = item.band;
	assign out_ch.ok    = item.ok;
	assign out_ch.last  = item.last;

endmodule

@@ sim/tb_rbb_filter_calibration_sequencer_top.sv @@
// self-checking testbench for the receive filter calibration sequencer top level
`timescale 1ns / 1ps

module tb_rbb_filter_calibration_sequencer_top;
	import rbfc_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_ITEMS  = 35;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_MODES    = 5;

	typedef struct packed {
		logic               op;
		logic [LEVEL_W-1:0] level;
	} cal_cmd_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_BIAS,
		SEQ_GAIN_FIRST,
		SEQ_GAIN,
		SEQ_BAND
	} seq_phase_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	rbfc_in_if  cmd_ch ();
	rbfc_out_if setting_ch ();

	rbb_filter_calibration_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (cmd_ch),
		.out_ch   (setting_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// register copies
	logic [LEVEL_W-1:0] thr_reg;
	logic [GAIN_W-1:0]  gain_start_reg;
	logic [VALUE_W-1:0] cap_start_reg;

	// sequencer copy
	seq_phase_t         seq_phase;
	logic [BIAS_W-1:0]  sweep_code;
	logic [BIAS_W-1:0]  quietest_code;
	logic [LEVEL_W-1:0] quietest_level;
	logic [GAIN_W-1:0]  gain_code;
	logic               gain_up;
	logic [LEVEL_W-1:0] target_level;
	logic [BAND_W-1:0]  band_sel;
	logic [VALUE_W-1:0] cap_code;

	res_t     step_results[$];
	res_t     expected_settings[$];
	cal_cmd_t pending_cmds[$];
	cal_cmd_t staged_cmds[$];

	int   queued_items;
	int   error_count;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_request = 1'b0;
	logic rx_hold;

	function automatic void emit_setting(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
		logic [BAND_W-1:0] band, logic ok);
		res_t r;
		r.kind  = kind;
		r.value = value;
		r.band  = band;
		r.ok    = ok;
		r.last  = 1'b0;
		step_results.push_back(r);
	endfunction

	function automatic void nudge_gain();
		if (gain_up) begin
			if (gain_code != GAIN_MAX) gain_code = gain_code + GAIN_W'(1);
		end else if (gain_code != '0) begin
			gain_code = gain_code - GAIN_W'(1);
		end
	endfunction

	function automatic void open_band();
		if (int'(band_sel) < NUM_BANDS) begin
			cap_code = cap_start_reg;
			emit_setting(K_CAP, cap_code, band_sel, 1'b0);
		end else begin
			seq_phase = SEQ_IDLE;
			emit_setting(K_DONE, '0, '0, 1'b1);
		end
	endfunction

	// works out the settings one transfer on the command channel causes
	function automatic void predict_measurement(cal_cmd_t cmd);
		int   ohms;
		logic finished;
		res_t r;
		step_results.delete();
		if (cmd.op == OP_START) begin
			seq_phase      = SEQ_BIAS;
			sweep_code     = '0;
			quietest_level = '0;
			quietest_code  = BIAS_DEFAULT;
			emit_setting(K_BIAS, '0, '0, 1'b0);
		end else begin
			case (seq_phase)
			SEQ_BIAS: begin
				if (sweep_code == '0) begin
					quietest_level = cmd.level;
				end else if (cmd.level < quietest_level) begin
					quietest_level = cmd.level;
					quietest_code  = sweep_code;
				end
				if (int'(sweep_code) + 1 < BIAS_STEPS) begin
					sweep_code = sweep_code + BIAS_W'(1);
					emit_setting(K_BIAS, VALUE_W'(sweep_code), '0, 1'b0);
				end else begin
					ohms = (quietest_code == '0) ? 31 : 256 / int'(quietest_code);
					if (ohms > 31) ohms = 31;
					gain_code = gain_start_reg;
					seq_phase = SEQ_GAIN_FIRST;
					emit_setting(K_BIAS, VALUE_W'(quietest_code), '0, 1'b0);
					emit_setting(K_RES, VALUE_W'(ohms), '0, 1'b0);
					emit_setting(K_GAIN, VALUE_W'(gain_code), '0, 1'b0);
				end
			end
			SEQ_GAIN_FIRST: begin
				gain_up = (cmd.level < thr_reg);
				nudge_gain();
				seq_phase = SEQ_GAIN;
				emit_setting(K_GAIN, VALUE_W'(gain_code), '0, 1'b0);
			end
			SEQ_GAIN: begin
				finished = gain_up ? (cmd.level >= thr_reg) : (cmd.level <= thr_reg);
				if (gain_code == '0 || gain_code == GAIN_MAX) finished = 1'b1;
				if (finished) begin
					target_level = cmd.level;
					band_sel     = '0;
					seq_phase    = SEQ_BAND;
					open_band();
				end else begin
					nudge_gain();
					emit_setting(K_GAIN, VALUE_W'(gain_code), '0, 1'b0);
				end
			end
			SEQ_BAND: begin
				if (cmd.level >= target_level) begin
					emit_setting(K_REPORT, cap_code, band_sel, 1'b1);
					band_sel = band_sel + BAND_W'(1);
					open_band();
				end else if (cap_code == '0) begin
					// band failed: capacitor exhausted below target
					emit_setting(K_REPORT, '0, band_sel, 1'b0);
					band_sel = band_sel + BAND_W'(1);
					open_band();
				end else begin
					cap_code = cap_code - VALUE_W'(1);
					emit_setting(K_CAP, cap_code, band_sel, 1'b0);
				end
			end
			default: ;
			endcase
		end
		for (int i = 0; i < step_results.size(); i++) begin
			r      = step_results[i];
			r.last = (i == step_results.size() - 1);
			expected_settings.push_back(r);
		end
	endfunction

	function automatic void note_mismatch(string msg);
		error_count++;
		if (error_count <= 10) $display("%0t: %s", $time, msg);
	endfunction

	function automatic logic [LEVEL_W-1:0] random_level();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		default: return LEVEL_W'($urandom);
		endcase
	endfunction

	// lim must be nonzero
	function automatic logic [LEVEL_W-1:0] level_under(logic [LEVEL_W-1:0] lim);
		return LEVEL_W'($urandom_range(int'(lim) - 1, 0));
	endfunction

	function automatic logic [LEVEL_W-1:0] level_from(logic [LEVEL_W-1:0] lim);
		if ($urandom_range(0, 3) == 0) return lim;
		return LEVEL_W'($urandom_range(65535, int'(lim)));
	endfunction

	function automatic void stage_cmd(logic op, logic [LEVEL_W-1:0] lvl);
		cal_cmd_t c;
		c.op    = op;
		c.level = lvl;
		staged_cmds.push_back(c);
	endfunction

	function automatic void commit_staged(int keep);
		for (int i = 0; i < keep; i++) pending_cmds.push_back(staged_cmds[i]);
		queued_items += keep;
		staged_cmds.delete();
	endfunction

	// one calibration run shaped to follow the sweep, gain search and band searches
	function automatic void queue_calibration_run(bit broken);
		int                 dip_code;
		int                 style;
		int                 misses;
		bit                 rising;
		logic [LEVEL_W-1:0] lvl;
		logic [LEVEL_W-1:0] tgt;
		stage_cmd(OP_START, LEVEL_W'($urandom));
		dip_code = $urandom_range(BIAS_STEPS - 1, 0);
		style    = $urandom_range(2, 0);
		lvl      = LEVEL_W'($urandom);
		for (int code = 0; code < BIAS_STEPS; code++) begin
			case (style)
			0: stage_cmd(OP_MEASURE, random_level());
			1: begin
				if (code == dip_code) stage_cmd(OP_MEASURE, LEVEL_W'($urandom_range(999, 0)));
				else stage_cmd(OP_MEASURE, LEVEL_W'($urandom_range(65535, 1000)));
			end
			default: stage_cmd(OP_MEASURE, lvl);	// all tied
			endcase
		end

		rising = (thr_reg != '0) && ($urandom_range(0, 1) == 1);
		stage_cmd(OP_MEASURE, rising ? level_under(thr_reg) : level_from(thr_reg));
		if (rising || thr_reg != '1) begin
			repeat ($urandom_range(0, 3))
				stage_cmd(OP_MEASURE,
					rising ? level_under(thr_reg) : level_from(thr_reg + LEVEL_W'(1)));
		end
		tgt = rising ? level_from(thr_reg) : LEVEL_W'($urandom_range(int'(thr_reg), 0));
		stage_cmd(OP_MEASURE, tgt);

		for (int b = 0; b < NUM_BANDS; b++) begin
			misses = (tgt == '0) ? 0 : $urandom_range(0, 3);
			if (misses > int'(cap_start_reg)) begin
				repeat (int'(cap_start_reg) + 1) stage_cmd(OP_MEASURE, level_under(tgt));
			end else begin
				repeat (misses) stage_cmd(OP_MEASURE, level_under(tgt));
				stage_cmd(OP_MEASURE, level_from(tgt));
			end
		end

		if (broken) commit_staged($urandom_range(staged_cmds.size() - 1, 1));
		else commit_staged(staged_cmds.size());
	endfunction

	function automatic void queue_noise();
		repeat ($urandom_range(1, 6))
			stage_cmd(($urandom_range(0, 4) == 0) ? OP_START : OP_MEASURE, random_level());
		commit_staged(staged_cmds.size());
	endfunction

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
		CFG_GAIN_THRESHOLD: thr_reg = data;
		CFG_GAIN_START: gain_start_reg = data[GAIN_W-1:0];
		CFG_CAP_START: cap_start_reg = data[VALUE_W-1:0];
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending_cmds.size() != 0 || cmd_ch.valid || expected_settings.size() != 0)
			@(negedge clk);
		// an ignored measurement keeps the block busy without a result
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : rx_hold_timer
		rx_hold = 1'b0;
		wait (hold_request);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin : cmd_driver
		cal_cmd_t taken;
		cal_cmd_t next_cmd;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken.op    = cmd_ch.op;
				taken.level = cmd_ch.level;
				predict_measurement(taken);
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_cmd = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.op    <= next_cmd.op;
					cmd_ch.level <= next_cmd.level;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		res_t got;
		res_t want;
		if (arst_n) begin
			if (setting_ch.valid && setting_ch.ready) begin
				got.kind  = setting_ch.kind;
				got.value = setting_ch.value;
				got.band  = setting_ch.band;
				got.ok    = setting_ch.ok;
				got.last  = setting_ch.last;
				if (expected_settings.size() == 0) begin
					note_mismatch($sformatf(
						"unexpected result kind %0d value %0d band %0d ok %0b last %0b",
						got.kind, got.value, got.band, got.ok, got.last));
				end else begin
					want = expected_settings.pop_front();
					if (got !== want)
						note_mismatch($sformatf({"expected kind %0d value %0d band %0d ok %0b",
							" last %0b, got kind %0d value %0d band %0d ok %0b last %0b"},
							want.kind, want.value, want.band, want.ok, want.last,
							got.kind, got.value, got.band, got.ok, got.last));
				end
			end
			setting_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin : stimulus
		int start_count;
		int pick;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_idx          = '0;
		cfg_data         = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.op        = OP_MEASURE;
		cmd_ch.level     = '0;
		setting_ch.ready = 1'b0;
		thr_reg          = GAIN_THRESHOLD_RST;
		gain_start_reg   = GAIN_START_RST;
		cap_start_reg    = CAP_START_RST;
		seq_phase        = SEQ_IDLE;
		sweep_code       = '0;
		quietest_level   = '0;
		quietest_code    = BIAS_DEFAULT;
		gain_code        = '0;
		gain_up          = 1'b0;
		target_level     = '0;
		band_sel         = '0;
		cap_code         = '0;
		error_count      = 0;
		queued_items     = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// measurements while idle are dropped; a start mid-run abandons the run
		stage_cmd(OP_MEASURE, '1);
		stage_cmd(OP_MEASURE, '0);
		stage_cmd(OP_START, 16'h5A5A);
		stage_cmd(OP_MEASURE, '0);
		stage_cmd(OP_MEASURE, '1);
		stage_cmd(OP_START, '1);
		stage_cmd(OP_MEASURE, 16'h8000);
		stage_cmd(OP_MEASURE, '0);
		commit_staged(staged_cmds.size());

		for (int mode = 0; mode < NUM_MODES; mode++) begin
			wait_drained();
			case (mode)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				hold_request   = 1'b1;
			end
			1: begin
				send_idle_pct  = 61;
				recv_stall_pct = 0;
				write_register(CFG_GAIN_THRESHOLD, '0);
				write_register(CFG_GAIN_START, 16'd62);
				write_register(CFG_CAP_START, '0);
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 61;
				write_register(CFG_GAIN_THRESHOLD, '1);
				write_register(CFG_GAIN_START, 16'd1);
				write_register(CFG_CAP_START, 16'd2047);
			end
			3: begin
				send_idle_pct  = 23;
				recv_stall_pct = 23;
				write_register(CFG_GAIN_THRESHOLD, CFG_DATA_W'($urandom));
				write_register(CFG_GAIN_START, 16'hFFFF);
				write_register(CFG_CAP_START, CFG_DATA_W'($urandom));
			end
			default: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
				write_register(CFG_GAIN_THRESHOLD, CFG_DATA_W'($urandom));
				write_register(CFG_GAIN_START, 16'hFFC0);
				write_register(CFG_CAP_START, CFG_DATA_W'($urandom_range(3, 0)));
			end
			endcase
			start_count = queued_items;
			while (queued_items - start_count < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) queue_calibration_run(1'b0);
				else if (pick < 8) queue_calibration_run(1'b1);
				else queue_noise();
			end
		end

		wait_drained();
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
